// File: hw/rtl/pixel_delta_color_filter_macros.svh
// Assertion macros for the pixel delta color filter.
// Needs clk_i and rst_ni in the scope that uses them; no other dependency.
`ifndef PIXEL_DELTA_COLOR_FILTER_MACROS_SVH
`define PIXEL_DELTA_COLOR_FILTER_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define PDCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PDCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PDCF_ASSERT_NOW(label, ante, cons, msg)
`define PDCF_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: hw/rtl/pdcf_pkg.sv
// Shared types and constants for the pixel delta color filter.
// No dependencies.
`default_nettype none

package pdcf_pkg;

  localparam int LaneSlots = 8;
  localparam int LaneW     = 8;
  localparam int CountW    = 4;
  localparam int CfgIdxW   = 2;

  typedef logic [LaneW-1:0]                 lane_t;
  typedef logic [LaneSlots-1:0][LaneW-1:0]  pixel_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_DIRECTION     = 2'd1,
    CFG_COLOR_XFORM   = 2'd2
  } cfg_idx_e;

  // Direction codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [CountW-1:0] ChannelCountRst = 4'd4;

endpackage

`default_nettype wire

// File: hw/rtl/pixel_delta_color_filter.sv
// Pixel delta color filter top level: horizontal byte-lane delta with GB-RG transform.
// Depends on pdcf_pkg and pixel_delta_color_filter_macros.svh.
//
//   channel   direction  handshake             payload
//   input     in         in_valid_i/in_ready_o  row_start_i, in_lane0_i..in_lane7_i
//   output    out        out_valid_o/out_ready_i out_lane0_o..out_lane7_o
//   config    in         cfg_we_i (no wait)     cfg_index_i, cfg_data_i
//
// One word in, one word out, one word per clock sustained while the output is not stalled.
// A word passes an input register, then one pass of byte adds/subtracts into the
// output register. The previous-pixel store is updated as a word moves from the
// input to the output register. A stalled output holds the input register; the input
// still takes a word as long as the input register empties in the same cycle.
// Reset (rst_ni low, asynchronous) empties both registers, zeroes the store and
// loads the register defaults (4 channels, encode, color transform on).
`default_nettype none
`include "pixel_delta_color_filter_macros.svh"

module pixel_delta_color_filter #(
  parameter int MAX_LANES = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write port
  input  wire logic                        cfg_we_i,
  input  wire logic [pdcf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [pdcf_pkg::CountW-1:0]  cfg_data_i,
  // input channel
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        row_start_i,
  input  wire logic [7:0]                  in_lane0_i,
  input  wire logic [7:0]                  in_lane1_i,
  input  wire logic [7:0]                  in_lane2_i,
  input  wire logic [7:0]                  in_lane3_i,
  input  wire logic [7:0]                  in_lane4_i,
  input  wire logic [7:0]                  in_lane5_i,
  input  wire logic [7:0]                  in_lane6_i,
  input  wire logic [7:0]                  in_lane7_i,
  // output channel
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [7:0]                       out_lane0_o,
  output logic [7:0]                       out_lane1_o,
  output logic [7:0]                       out_lane2_o,
  output logic [7:0]                       out_lane3_o,
  output logic [7:0]                       out_lane4_o,
  output logic [7:0]                       out_lane5_o,
  output logic [7:0]                       out_lane6_o,
  output logic [7:0]                       out_lane7_o
);

  localparam int Slots = pdcf_pkg::LaneSlots;
  localparam logic [pdcf_pkg::CountW-1:0] MaxLanesC = pdcf_pkg::CountW'(MAX_LANES);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [pdcf_pkg::CountW-1:0] chan_cnt_q;
  logic                        dir_q;
  logic                        xform_on_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= pdcf_pkg::ChannelCountRst;
      dir_q      <= pdcf_pkg::DIR_ENCODE;
      xform_on_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (pdcf_pkg::cfg_idx_e'(cfg_index_i))
        pdcf_pkg::CFG_CHANNEL_COUNT: chan_cnt_q <= cfg_data_i;
        pdcf_pkg::CFG_DIRECTION:     dir_q      <= cfg_data_i[0];
        pdcf_pkg::CFG_COLOR_XFORM:   xform_on_q <= cfg_data_i[0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // Effective lane count: zero means one lane, saturate at MAX_LANES.
  logic [pdcf_pkg::CountW-1:0] lanes_n;
  logic                        xform;

  always_comb begin
    if (chan_cnt_q == '0) begin
      lanes_n = pdcf_pkg::CountW'(1);
    end else if (chan_cnt_q > MaxLanesC) begin
      lanes_n = MaxLanesC;
    end else begin
      lanes_n = chan_cnt_q;
    end
  end

  // Color transform only applies to three or four channels.
  assign xform = xform_on_q &&
                 (lanes_n == pdcf_pkg::CountW'(3) || lanes_n == pdcf_pkg::CountW'(4));

  // ---------------------------------------------------------------------------
  // Pipeline handshake: input register feeds the output register
  // ---------------------------------------------------------------------------
  logic              s1_valid_q;
  logic              s1_row_q;
  pdcf_pkg::pixel_t  s1_pix_q;
  logic              out_valid_q;
  pdcf_pkg::pixel_t  out_pix_q;
  logic              adv;

  // Advance the input register whenever the output register is free or draining.
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_row_q    <= row_start_i;
      s1_pix_q[0] <= in_lane0_i;
      s1_pix_q[1] <= in_lane1_i;
      s1_pix_q[2] <= in_lane2_i;
      s1_pix_q[3] <= in_lane3_i;
      s1_pix_q[4] <= in_lane4_i;
      s1_pix_q[5] <= in_lane5_i;
      s1_pix_q[6] <= in_lane6_i;
      s1_pix_q[7] <= in_lane7_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Previous-pixel store: always holds the raw pixel, one byte per lane
  // ---------------------------------------------------------------------------
  logic [MAX_LANES-1:0][pdcf_pkg::LaneW-1:0] prev_q;
  pdcf_pkg::pixel_t prev_slot;  // store widened to all lane slots
  pdcf_pkg::pixel_t prev_next;  // store contents after this word

  for (genvar g = 0; g < Slots; g++) begin : g_slot
    if (g < MAX_LANES) begin : g_store
      assign prev_slot[g] = prev_q[g];

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          prev_q[g] <= '0;
        end else if (adv) begin
          prev_q[g] <= prev_next[g];
        end
      end
    end else begin : g_none
      assign prev_slot[g] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Filter datapath
  // ---------------------------------------------------------------------------
  pdcf_pkg::pixel_t prev_eff;  // store after row-start clear
  pdcf_pkg::pixel_t diff;      // per-lane encode delta
  pdcf_pkg::pixel_t enc;       // encoded word after transform
  pdcf_pkg::pixel_t xin;       // decode input with transform undone
  pdcf_pkg::pixel_t dec;       // restored pixel
  pdcf_pkg::pixel_t res;       // result word

  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      prev_eff[i] = s1_row_q ? '0 : prev_slot[i];
      diff[i]     = s1_pix_q[i] - prev_eff[i];
    end

    // Encode: y = db, u = dg - db, v = dg - dr; alpha stays a plain delta.
    enc = diff;
    if (xform) begin
      enc[0] = diff[2];
      enc[1] = diff[1] - diff[2];
      enc[2] = diff[1] - diff[0];
    end

    // Decode: b = y, g = u + b, r = g - v, then add the previous pixel back.
    xin = s1_pix_q;
    if (xform) begin
      xin[2] = s1_pix_q[0];
      xin[1] = s1_pix_q[1] + s1_pix_q[0];
      xin[0] = xin[1] - s1_pix_q[2];
    end
    for (int i = 0; i < Slots; i++) begin
      dec[i] = xin[i] + prev_eff[i];
    end

    // Lanes past the count give zero and keep their (possibly cleared) store byte.
    for (int i = 0; i < Slots; i++) begin
      if (pdcf_pkg::CountW'(i) < lanes_n) begin
        res[i]       = (dir_q == pdcf_pkg::DIR_DECODE) ? dec[i] : enc[i];
        prev_next[i] = (dir_q == pdcf_pkg::DIR_DECODE) ? dec[i] : s1_pix_q[i];
      end else begin
        res[i]       = '0;
        prev_next[i] = prev_eff[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pix_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_lane0_o = out_pix_q[0];
  assign out_lane1_o = out_pix_q[1];
  assign out_lane2_o = out_pix_q[2];
  assign out_lane3_o = out_pix_q[3];
  assign out_lane4_o = out_pix_q[4];
  assign out_lane5_o = out_pix_q[5];
  assign out_lane6_o = out_pix_q[6];
  assign out_lane7_o = out_pix_q[7];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A full pipeline with a stalled output must refuse new words.
  `PDCF_ASSERT_NOW(a_full_stall, s1_valid_q && out_valid_q && !out_ready_i, !in_ready_o, "input taken while pipeline full")
  // A word that advances always lands in the output register.
  `PDCF_ASSERT_NEXT(a_adv_lands, adv, out_valid_q, "advanced word lost")
  // Encoding stores the raw byte of lane 0, which is always in use.
  `PDCF_ASSERT_NEXT(a_enc_store, adv && dir_q == pdcf_pkg::DIR_ENCODE, prev_slot[0] == $past(s1_pix_q[0]), "store does not hold raw pixel")
  // At row start without transform the lane-0 result equals the input byte.
  `PDCF_ASSERT_NEXT(a_row_start, adv && s1_row_q && !xform, out_pix_q[0] == $past(s1_pix_q[0]), "row start did not clear store")

endmodule

`default_nettype wire
